[design/bn_pkg.sv]
`timescale 1ns / 1ps

package bn_pkg;

    localparam int unsigned CHANNELS_DEF = 512;
    localparam int unsigned CH_W         = 9;
    localparam int unsigned SQRT_STEPS   = 25;
    localparam int unsigned DIV_STEPS    = 40;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        LD_IDLE,
        LD_SQRT,
        LD_DIV,
        LD_MUL,
        LD_OFS,
        LD_WRITE
    } ld_state_t;

    // coefficient write toward the channel tables
    typedef struct packed {
        logic               valid;
        logic [CH_W-1:0]    channel;
        logic signed [31:0] scale;
        logic signed [31:0] offset;
    } coef_wr_t;

endpackage

[design/bn_coef_unit.sv]
`timescale 1ns / 1ps

module bn_coef_unit
    import bn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CH_W-1:0]      channel,
    input  logic signed [15:0]   coef_gamma,
    input  logic signed [15:0]   coef_beta,
    input  logic signed [15:0]   coef_mean,
    input  logic [31:0]          coef_variance,
    input  logic [15:0]          epsilon,
    output logic                 busy,
    output coef_wr_t             wr
);

    ld_state_t state_reg, state_next;

    logic [5:0]          cnt_reg;
    logic [CH_W-1:0]     ch_reg;
    logic signed [15:0]  gamma_reg, beta_reg, mean_reg;
    logic [49:0]         v_reg, r_reg, bit_reg;
    logic [24:0]         d_reg;
    logic [39:0]         num_reg;
    logic [24:0]         rem_reg;
    logic signed [31:0]  scale_reg, offset_reg;
    logic signed [47:0]  prod_reg;

    logic [49:0]         sq_t;
    logic                sq_ge;
    logic [25:0]         rem_sh;
    logic                div_ge;
    logic [15:0]         gamma_mag;
    logic [32:0]         s_sum;
    logic signed [47:0]  prod_rnd;
    logic signed [48:0]  off_full;
    logic signed [31:0]  scale_sat;
    logic signed [31:0]  off_sat;

    assign s_sum     = {1'b0, coef_variance} + {17'd0, epsilon};
    assign gamma_mag = gamma_reg[15] ? 16'(-gamma_reg) : gamma_reg;
    assign sq_t      = r_reg + bit_reg;
    assign sq_ge     = v_reg >= sq_t;
    assign rem_sh    = {rem_reg, num_reg[39]};
    assign div_ge    = rem_sh >= {1'b0, d_reg};
    assign prod_rnd  = (prod_reg + 48'sd128) >>> 8;
    assign off_full  = 49'(signed'({beta_reg, 8'd0})) - 49'(prod_rnd);

    always_comb
    begin
        // num_reg now holds the rounded quotient magnitude
        if (gamma_reg[15])
            scale_sat = (num_reg > 40'h80000000) ? 32'sh80000000 : 32'(-num_reg);
        else
            scale_sat = (num_reg > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(num_reg);
    end

    always_comb
    begin
        if (off_full > 49'sh7FFFFFFF)
            off_sat = 32'sh7FFFFFFF;
        else if (off_full < -49'sh80000000)
            off_sat = 32'sh80000000;
        else
            off_sat = 32'(off_full);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LD_IDLE:  if (start) state_next = LD_SQRT;
            LD_SQRT:  if (cnt_reg == 6'(SQRT_STEPS - 1)) state_next = LD_DIV;
            LD_DIV:   if (d_reg == '0 || cnt_reg == 6'(DIV_STEPS - 1)) state_next = LD_MUL;
            LD_MUL:   state_next = LD_OFS;
            LD_OFS:   state_next = LD_WRITE;
            LD_WRITE: state_next = LD_IDLE;
            default:  state_next = LD_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = (state_reg != LD_IDLE);
        wr.valid   = (state_reg == LD_WRITE);
        wr.channel = ch_reg;
        wr.scale   = scale_reg;
        wr.offset  = offset_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LD_IDLE:
            begin
                ch_reg    <= channel;
                gamma_reg <= coef_gamma;
                beta_reg  <= coef_beta;
                mean_reg  <= coef_mean;
                v_reg     <= {1'b0, s_sum, 16'd0};
                r_reg     <= '0;
                bit_reg   <= 50'd1 << 48;
            end
            LD_SQRT:
            begin
                // one result bit per cycle
                if (sq_ge)
                begin
                    v_reg <= v_reg - sq_t;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                    r_reg <= r_reg >> 1;
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                begin
                    d_reg   <= sq_ge ? 25'((r_reg >> 1) + bit_reg) : 25'(r_reg >> 1);
                    rem_reg <= '0;
                    num_reg <= {gamma_mag, 24'd0}
                             + 40'(sq_ge ? 25'((r_reg >> 1) + bit_reg) >> 1
                                         : 25'(r_reg >> 1) >> 1);
                end
            end
            LD_DIV:
            begin
                if (d_reg == '0)
                begin
                    if (gamma_reg == '0)
                        num_reg <= '0;
                    else
                        num_reg <= '1;  // saturates below
                end
                else
                begin
                    rem_reg <= div_ge ? 25'(rem_sh - {1'b0, d_reg}) : rem_sh[24:0];
                    num_reg <= {num_reg[38:0], div_ge};
                end
            end
            LD_MUL:
            begin
                scale_reg <= scale_sat;
                prod_reg  <= 48'(mean_reg) * 48'(scale_sat);
            end
            LD_OFS:
                offset_reg <= off_sat;
            default:
            begin
            end
        endcase
    end

endmodule

[design/batchnorm_inference.sv]
`timescale 1ns / 1ps
// Per-channel batch normalization for inference, signed Q8.8 in and out.
// Input channel (in_valid/in_ready) carries one word per item. operation
// selects a coefficient load (gamma, beta, mean, variance for one channel)
// or a sample. A sample returns one word on the output channel
// (out_valid/out_ready): sample*scale+offset rounded and saturated, with
// channel and end-of-plane flag copied. Loads return nothing.
// Samples stream one per cycle unless a load runs or the receiver stalls;
// results pass the table read, multiply and add/round/saturate stages.
// A load in range holds in_ready low while the shared square-root and
// divider, each one result bit per step, compute scale, then through the
// offset multiply, the offset subtract and the table write. With variance
// plus epsilon of zero the divider is skipped.
// Loads to a channel beyond CHANNELS are dropped; samples there give 0.
// epsilon is written on cfg_valid/cfg_ready (always ready), reset value 1.
// Reset clears the pipeline valid bits and the load sequencer; the tables
// hold nothing defined until loaded.
// When the receiver stalls the whole pipeline holds in place and in_ready
// falls, so no word is dropped or repeated.
module batchnorm_inference
    import bn_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [CH_W-1:0]    channel,
    input  logic signed [15:0] sample,
    input  logic signed [15:0] coef_gamma,
    input  logic signed [15:0] coef_beta,
    input  logic signed [15:0] coef_mean,
    input  logic [31:0]        coef_variance,
    input  logic               last_in_plane,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] normalized,
    output logic [CH_W-1:0]    out_channel,
    output logic               out_last_in_plane,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [15:0] epsilon_reg;

    logic signed [31:0] scale_mem  [CHANNELS];
    logic signed [31:0] offset_mem [CHANNELS];

    logic               busy;
    coef_wr_t           wr;
    logic               pipe_en;
    logic               in_fire;
    logic               ch_ok;

    // stage 1: table read
    logic               v1_reg, ok1_reg, last1_reg;
    logic [CH_W-1:0]    ch1_reg;
    logic signed [15:0] x1_reg;
    logic signed [31:0] sc1_reg, of1_reg;
    // stage 2: product
    logic               v2_reg, ok2_reg, last2_reg;
    logic [CH_W-1:0]    ch2_reg;
    logic signed [47:0] prod2_reg;
    logic signed [31:0] of2_reg;
    // stage 3: output register
    logic               v3_reg, last3_reg;
    logic [CH_W-1:0]    ch3_reg;
    logic signed [15:0] res3_reg;

    logic signed [49:0] acc;
    logic signed [33:0] acc_sh;
    logic signed [15:0] res_next;

    assign ch_ok     = 32'(channel) < CHANNELS;
    assign pipe_en   = !v3_reg || out_ready;
    assign in_ready  = pipe_en && !busy;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            epsilon_reg <= 16'd1;
        else if (cfg_valid)
            epsilon_reg <= cfg_data;
    end

    bn_coef_unit u_coef (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_fire && operation == OP_LOAD && ch_ok),
        .channel       (channel),
        .coef_gamma    (coef_gamma),
        .coef_beta     (coef_beta),
        .coef_mean     (coef_mean),
        .coef_variance (coef_variance),
        .epsilon       (epsilon_reg),
        .busy          (busy),
        .wr            (wr)
    );

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            scale_mem[AW'(wr.channel)]  <= wr.scale;
            offset_mem[AW'(wr.channel)] <= wr.offset;
        end
        if (pipe_en)
        begin
            sc1_reg <= scale_mem[AW'(channel)];
            of1_reg <= offset_mem[AW'(channel)];
        end
    end

    // round half up, then saturate to Q8.8
    assign acc    = 50'(prod2_reg) + 50'(signed'({of2_reg, 8'd0})) + 50'sd32768;
    assign acc_sh = 34'(acc >>> 16);

    always_comb
    begin
        if (!ok2_reg)
            res_next = '0;
        else if (acc_sh > 34'sd32767)
            res_next = 16'sh7FFF;
        else if (acc_sh < -34'sd32768)
            res_next = 16'sh8000;
        else
            res_next = 16'(acc_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= in_fire && operation == OP_SAMPLE;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ok1_reg   <= ch_ok;
            ch1_reg   <= channel;
            x1_reg    <= sample;
            last1_reg <= last_in_plane;

            ok2_reg   <= ok1_reg;
            ch2_reg   <= ch1_reg;
            last2_reg <= last1_reg;
            of2_reg   <= of1_reg;
            prod2_reg <= 48'(x1_reg) * 48'(sc1_reg);

            ch3_reg   <= ch2_reg;
            last3_reg <= last2_reg;
            res3_reg  <= res_next;
        end
    end

    assign out_valid         = v3_reg;
    assign normalized        = res3_reg;
    assign out_channel       = ch3_reg;
    assign out_last_in_plane = last3_reg;

endmodule

[design/bn_chk.sv]
`timescale 1ns / 1ps

module bn_chk
    import bn_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               operation,
    input logic [CH_W-1:0]    channel,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] normalized,
    input logic [CH_W-1:0]    out_channel
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(normalized)
                                    && $stable(out_channel))
        else $error("output word changed while stalled");

    // an in-range load blocks the next word
    a_load_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_LOAD && 32'(channel) < CHANNELS
        |=> !in_ready)
        else $error("input taken during coefficient load");

    // unknown channel gives zero
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && 32'(out_channel) >= CHANNELS |-> normalized == 16'sd0)
        else $error("out-of-range channel gave nonzero result");

    // a load accepted with the output ready throughout never makes a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_LOAD && out_ready
        ##1 out_ready ##1 out_ready |=> !out_valid)
        else $error("load produced a result");

endmodule

bind batchnorm_inference bn_chk #(.CHANNELS(CHANNELS)) u_bn_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .channel     (channel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .normalized  (normalized),
    .out_channel (out_channel)
);
